// File: src/slt_pkg.sv
`timescale 1ns / 1ps
package slt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_SPLIT  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_WAIT,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SPL_RD,
    ST_SPL_OUT,
    ST_REPLY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture op, key, value
    logic ins_init;  // reset scan pointer, shift pointer to count
    logic scan_rd;   // read entry at scan pointer
    logic scan_adv;  // scan pointer up by one
    logic shift_rd;  // read entry at shift pointer - 1
    logic shift_wr;  // write read data to shift pointer, step down
    logic put_wr;    // write new pair at shift pointer, count up
    logic find_init; // lo = 0, hi = count - 1
    logic find_rd;   // read at mid
    logic find_step; // narrow the range
    logic spl_init;  // pointer at keep
    logic spl_rd;    // read at pointer
    logic spl_emit;  // stream entry, pointer up
    logic spl_done;  // count = keep
    logic reply;     // single result
    logic reply_ok;
    logic reply_val; // include found value
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic scan_end;  // scan pointer reached count
    logic scan_less; // entry at scan pointer < key
    logic shift_end; // shift pointer equals scan pointer
    logic range_ok;  // lo <= hi
    logic hit;       // probed key equals key
    logic spl_last;  // pointer is the top entry
  } sts_t;

endpackage

// File: src/sorted_leaf_table_core.sv
`timescale 1ns / 1ps
// sorted key/value leaf table with insert, find and split. a transaction is
// taken when start_i is high and busy_o low; every result appears for one
// cycle with done_o high and cannot be held off, so the receiver must take
// it then. last_o marks the final result of a transaction. insert scans
// the sorted entries one per cycle and then shifts the upper ones up one at
// a time, each read and then written back, through the single write port.
// find is a binary search, each probe a read and then a compare. split
// streams the upper entries, each read and then emitted. no clearing pass
// after reset.
module sorted_leaf_table_core #(
  parameter int KEY_SLOTS  = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [63:0] key_out_o,
  output logic [63:0] value_out_o,
  output logic        last_o
);
  slt_pkg::ctl_t ctl;
  slt_pkg::sts_t sts;

  // sequencer
  slt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .ctl_o(ctl)
  );

  // storage, pointers and compares
  slt_dp #(.KeySlots(KEY_SLOTS), .ValueBits(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .operation_i, .key_i, .value_i,
    .ctl_i(ctl), .sts_o(sts), .done_o, .ok_o, .key_out_o, .value_out_o, .last_o
  );
endmodule

// File: src/slt_ram.sv
`timescale 1ns / 1ps
module slt_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/slt_ctrl.sv
`timescale 1ns / 1ps
module slt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  slt_pkg::sts_t  sts_i,
  output slt_pkg::ctl_t  ctl_o
);
  slt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= slt_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slt_pkg::ST_IDLE: begin
        if (start_i) begin
          // op decoded in next state from captured op
          state_d = slt_pkg::ST_INS_SCAN;
        end
      end
      slt_pkg::ST_INS_SCAN: begin
        // first cycle after capture: dispatch
        unique case (sts_i.op)
          slt_pkg::OP_INSERT: state_d = sts_i.full ? slt_pkg::ST_REPLY : slt_pkg::ST_INS_WAIT;
          slt_pkg::OP_FIND:   state_d = slt_pkg::ST_FIND_RD;
          slt_pkg::OP_SPLIT:  state_d = sts_i.empty ? slt_pkg::ST_REPLY : slt_pkg::ST_SPL_RD;
          default:            state_d = slt_pkg::ST_REPLY;
        endcase
      end
      slt_pkg::ST_INS_WAIT: begin
        // read data of scan pointer is valid here
        if (sts_i.scan_end || !sts_i.scan_less) begin
          state_d = sts_i.shift_end ? slt_pkg::ST_INS_PUT : slt_pkg::ST_INS_SHIFT;
        end
      end
      slt_pkg::ST_INS_SHIFT: state_d = slt_pkg::ST_INS_PUT;
      slt_pkg::ST_INS_PUT: begin
        state_d = sts_i.shift_end ? slt_pkg::ST_REPLY : slt_pkg::ST_INS_SHIFT;
      end
      slt_pkg::ST_FIND_RD: begin
        state_d = sts_i.range_ok ? slt_pkg::ST_FIND_CMP : slt_pkg::ST_REPLY;
      end
      slt_pkg::ST_FIND_CMP: begin
        state_d = sts_i.hit ? slt_pkg::ST_REPLY : slt_pkg::ST_FIND_RD;
      end
      slt_pkg::ST_SPL_RD:  state_d = slt_pkg::ST_SPL_OUT;
      slt_pkg::ST_SPL_OUT: state_d = sts_i.spl_last ? slt_pkg::ST_IDLE : slt_pkg::ST_SPL_RD;
      slt_pkg::ST_REPLY:   state_d = slt_pkg::ST_IDLE;
      default:             state_d = slt_pkg::ST_IDLE;
    endcase
  end

  // remember whether the reply is a find hit or an accepted insert
  logic hit_q, hit_d;
  logic ins_ok_q, ins_ok_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      ins_ok_q <= 1'b0;
    end else begin
      hit_q    <= hit_d;
      ins_ok_q <= ins_ok_d;
    end
  end

  always_comb begin
    ctl_o    = '0;
    busy_o   = (state_q != slt_pkg::ST_IDLE);
    hit_d    = hit_q;
    ins_ok_d = ins_ok_q;
    unique case (state_q)
      slt_pkg::ST_IDLE: begin
        ctl_o.load = start_i;
        hit_d      = 1'b0;
        ins_ok_d   = 1'b0;
      end
      slt_pkg::ST_INS_SCAN: begin
        ctl_o.ins_init  = 1'b1;
        ctl_o.find_init = 1'b1;
        ctl_o.spl_init  = 1'b1;
        ctl_o.scan_rd   = 1'b1;
      end
      slt_pkg::ST_INS_WAIT: begin
        if (!(sts_i.scan_end || !sts_i.scan_less)) begin
          ctl_o.scan_adv = 1'b1;
          ctl_o.scan_rd  = 1'b1;
        end else begin
          ctl_o.shift_rd = 1'b1;
        end
      end
      slt_pkg::ST_INS_SHIFT: ctl_o.shift_wr = 1'b1;
      slt_pkg::ST_INS_PUT: begin
        if (sts_i.shift_end) begin
          ctl_o.put_wr = 1'b1;
          ins_ok_d     = 1'b1;
        end else begin
          ctl_o.shift_rd = 1'b1;
        end
      end
      slt_pkg::ST_FIND_RD: ctl_o.find_rd = sts_i.range_ok;
      slt_pkg::ST_FIND_CMP: begin
        ctl_o.find_step = !sts_i.hit;
        hit_d           = sts_i.hit;
      end
      slt_pkg::ST_SPL_RD: ctl_o.spl_rd = 1'b1;
      slt_pkg::ST_SPL_OUT: begin
        ctl_o.spl_emit = 1'b1;
        ctl_o.spl_done = sts_i.spl_last;
      end
      slt_pkg::ST_REPLY: begin
        ctl_o.reply     = 1'b1;
        ctl_o.reply_ok  = hit_q || ins_ok_q;
        ctl_o.reply_val = hit_q;
      end
      default: ;
    endcase
  end
endmodule

// File: src/slt_dp.sv
`timescale 1ns / 1ps
module slt_dp #(
  parameter int KeySlots  = 32,
  parameter int ValueBits = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           operation_i,
  input  logic [63:0]          key_i,
  input  logic [63:0]          value_i,
  input  slt_pkg::ctl_t        ctl_i,
  output slt_pkg::sts_t        sts_o,
  output logic                 done_o,
  output logic                 ok_o,
  output logic [63:0]          key_out_o,
  output logic [63:0]          value_out_o,
  output logic                 last_o
);
  localparam int Aw = $clog2(KeySlots);
  localparam int Cw = $clog2(KeySlots + 1);

  logic [1:0]           op_q;
  logic [63:0]          key_q;
  logic [ValueBits-1:0] val_q;
  logic [Cw-1:0]        cnt_q;
  logic [Cw-1:0]        scan_q;   // insert position
  logic [Cw-1:0]        shp_q;    // shift pointer, starts at count
  logic [Cw:0]          lo_q, hi_q; // signed range, one bit wider
  logic [Cw-1:0]        mid;
  logic [Cw-1:0]        sp_q;     // split pointer
  logic [Cw-1:0]        keep;

  logic                 we;
  logic [Aw-1:0]        waddr, raddr;
  logic [63:0]          kw, kr;
  logic [ValueBits-1:0] vw, vr;

  assign keep = cnt_q >> 1;
  logic [Cw:0] sum;
  assign sum = lo_q + hi_q;
  assign mid = sum[Cw:1];

  always_comb begin
    raddr = '0;
    if (ctl_i.scan_rd)
      raddr = ctl_i.scan_adv ? Aw'(scan_q + 1'b1) : Aw'(scan_q);
    if (ctl_i.ins_init) raddr = '0;
    if (ctl_i.shift_rd) raddr = Aw'(shp_q - 1'b1);
    if (ctl_i.find_rd)  raddr = Aw'(mid);
    if (ctl_i.spl_rd)   raddr = Aw'(sp_q);
  end

  always_comb begin
    we    = ctl_i.shift_wr | ctl_i.put_wr;
    waddr = Aw'(shp_q);
    kw    = ctl_i.put_wr ? key_q : kr;
    vw    = ctl_i.put_wr ? val_q : vr;
  end

  slt_ram #(.Width(64), .Depth(KeySlots)) u_keys (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(kw), .raddr_i(raddr), .rdata_o(kr)
  );
  slt_ram #(.Width(ValueBits), .Depth(KeySlots)) u_vals (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(vw), .raddr_i(raddr), .rdata_o(vr)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= key_i;
      val_q <= value_i[ValueBits-1:0];
    end
    if (ctl_i.ins_init) begin
      scan_q <= '0;
      shp_q  <= cnt_q;
    end
    if (ctl_i.scan_adv) scan_q <= scan_q + 1'b1;
    if (ctl_i.shift_wr) shp_q  <= shp_q - 1'b1;
    if (ctl_i.find_init) begin
      lo_q <= '0;
      hi_q <= {1'b0, cnt_q} - 1'b1;
    end
    if (ctl_i.find_step) begin
      if (kr < key_q) lo_q <= {1'b0, mid} + 1'b1;
      else            hi_q <= {1'b0, mid} - 1'b1;
    end
    if (ctl_i.spl_init) sp_q <= keep;
    if (ctl_i.spl_emit) sp_q <= sp_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      op_q  <= slt_pkg::OP_NONE;
    end else begin
      if (ctl_i.load)     op_q  <= operation_i;
      if (ctl_i.put_wr)   cnt_q <= cnt_q + 1'b1;
      if (ctl_i.spl_done) cnt_q <= keep;
    end
  end

  always_comb begin
    sts_o.op        = slt_pkg::op_e'(op_q);
    sts_o.full      = (cnt_q == Cw'(KeySlots));
    sts_o.empty     = (cnt_q == '0);
    sts_o.scan_end  = (scan_q == cnt_q);
    sts_o.scan_less = (kr < key_q);
    sts_o.shift_end = (shp_q == scan_q);
    sts_o.range_ok  = !hi_q[Cw] && (lo_q <= hi_q);
    sts_o.hit       = (kr == key_q);
    sts_o.spl_last  = (sp_q + 1'b1 == cnt_q);
  end

  // found value held from compare cycle
  logic [ValueBits-1:0] fv_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.find_step || ctl_i.find_rd == 1'b0) fv_q <= vr;
  end

  always_comb begin
    done_o      = ctl_i.reply | ctl_i.spl_emit;
    ok_o        = ctl_i.spl_emit | ctl_i.reply_ok;
    key_out_o   = ctl_i.spl_emit ? kr : 64'd0;
    value_out_o = '0;
    if (ctl_i.spl_emit)       value_out_o = 64'(vr);
    else if (ctl_i.reply_val) value_out_o = 64'(fv_q);
    last_o      = ctl_i.reply | ctl_i.spl_done;
  end
endmodule

// File: bench/sorted_leaf_table_checker.sv
`timescale 1ns / 1ps
module sorted_leaf_table_checker #(
  parameter int KEY_SLOTS  = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  input  logic        done_i,
  input  logic        ok_i,
  input  logic [63:0] key_out_i,
  input  logic [63:0] value_out_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic        ok;
    logic [63:0] key;
    logic [63:0] value;
    logic        last;
  } leaf_result_t;

  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  logic [63:0]  leaf_keys [KEY_SLOTS];
  logic [63:0]  leaf_vals [KEY_SLOTS];
  int           leaf_count;
  leaf_result_t leaf_results_q [$];
  int           errors;

  assign errors_o  = errors;
  assign pending_o = leaf_results_q.size();

  function automatic leaf_result_t mk_result(logic ok, logic [63:0] k, logic [63:0] v,
                                             logic lst);
    leaf_result_t r;
    r.ok = ok;
    r.key = k;
    r.value = v;
    r.last = lst;
    return r;
  endfunction

  // apply one transaction to the shadow table and queue what it must produce
  task automatic predict_leaf(slt_pkg::op_e op, logic [63:0] k, logic [63:0] v);
    int pos;
    int lo;
    int hi;
    int mid;
    int keep;
    logic hit;
    logic [63:0] found;
    case (op)
      slt_pkg::OP_INSERT: begin
        if (leaf_count >= KEY_SLOTS) begin
          leaf_results_q.push_back(mk_result(1'b0, '0, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < leaf_count && leaf_keys[pos] < k) pos++;
          for (int i = leaf_count; i > pos; i--) begin
            leaf_keys[i] = leaf_keys[i-1];
            leaf_vals[i] = leaf_vals[i-1];
          end
          leaf_keys[pos] = k;
          leaf_vals[pos] = v & VALUE_MASK;
          leaf_count++;
          leaf_results_q.push_back(mk_result(1'b1, '0, '0, 1'b1));
        end
      end
      slt_pkg::OP_FIND: begin
        lo = 0;
        hi = leaf_count - 1;
        hit = 1'b0;
        found = '0;
        while (!hit && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (leaf_keys[mid] == k) begin
            hit = 1'b1;
            found = leaf_vals[mid];
          end else if (leaf_keys[mid] < k) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        leaf_results_q.push_back(mk_result(hit, '0, found, 1'b1));
      end
      slt_pkg::OP_SPLIT: begin
        if (leaf_count == 0) begin
          leaf_results_q.push_back(mk_result(1'b0, '0, '0, 1'b1));
        end else begin
          keep = leaf_count / 2;
          for (int i = keep; i < leaf_count; i++)
            leaf_results_q.push_back(mk_result(1'b1, leaf_keys[i], leaf_vals[i],
                                               i + 1 == leaf_count));
          leaf_count = keep;
        end
      end
      default: begin
        leaf_results_q.push_back(mk_result(1'b0, '0, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    leaf_result_t want;
    leaf_result_t got;
    if (!rst_ni) begin
      leaf_count = 0;
      errors = 0;
      leaf_results_q.delete();
    end else begin
      if (start_i && !busy_i)
        predict_leaf(slt_pkg::op_e'(operation_i), key_i, value_i);
      if (done_i) begin
        got = mk_result(ok_i, key_out_i, value_out_i, last_i);
        if (leaf_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = leaf_results_q.pop_front();
          if (got.ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch, expected %b, actual %b", $time, want.ok, got.ok);
          end
          if (got.key !== want.key) begin
            errors++;
            $display("%0t: key_out mismatch, expected %h, actual %h", $time, want.key,
                     got.key);
          end
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: value_out mismatch, expected %h, actual %h", $time,
                     want.value, got.value);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %b, actual %b", $time, want.last,
                     got.last);
          end
        end
      end
    end
  end

endmodule

// File: bench/sorted_leaf_table_core_tb.sv
`timescale 1ns / 1ps
module sorted_leaf_table_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 220;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  operation_i = slt_pkg::OP_NONE;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        ok_o;
  logic [63:0] key_out_o;
  logic [63:0] value_out_o;
  logic        last_o;
  int          errors;
  int          pending;
  int          cycles;
  int          op_tally [4];
  logic        allow_idle;

  sorted_leaf_table_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .key_i, .value_i,
    .done_o, .ok_o, .key_out_o, .value_out_o, .last_o
  );

  // checker follows both channels and keeps its own copy of the table
  sorted_leaf_table_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .key_i, .value_i,
    .done_i(done_o), .ok_i(ok_o), .key_out_i(key_out_o), .value_out_i(value_out_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // hold one transaction on the ports until the block takes it;
  // busy_o read right after the edge still holds its pre-edge value
  task automatic issue_op(slt_pkg::op_e op, logic [63:0] k, logic [63:0] v);
    start_i     <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    do @(posedge clk_i); while (busy_o);
    op_tally[op]++;
  endtask

  // random idle gap on the sender side, now and then
  task automatic maybe_idle();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // keys mostly from a small pool so that finds hit and duplicates pile up
  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 20));
    endcase
  endfunction

  // let a clock edge pass first so the checker has seen the last accepted transaction
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int split_weight;
    int roll;
    slt_pkg::op_e op;
    allow_idle = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, unused code, extremes, duplicates, split sizes
    issue_op(slt_pkg::OP_SPLIT, '1, '1);
    issue_op(slt_pkg::OP_FIND, 64'd5, '0);
    issue_op(slt_pkg::OP_NONE, '1, '1);
    issue_op(slt_pkg::OP_INSERT, '0, '0);
    issue_op(slt_pkg::OP_INSERT, '1, '1);
    issue_op(slt_pkg::OP_INSERT, 64'd5, 64'haaaa_aaaa_aaaa_aaaa);
    issue_op(slt_pkg::OP_INSERT, 64'd5, 64'h5555_5555_5555_5555);
    issue_op(slt_pkg::OP_INSERT, 64'd3, 64'h8000_0000_0000_0001);
    issue_op(slt_pkg::OP_FIND, 64'd5, '0);
    issue_op(slt_pkg::OP_FIND, '0, '0);
    issue_op(slt_pkg::OP_FIND, '1, '0);
    issue_op(slt_pkg::OP_FIND, 64'd4, '0);
    issue_op(slt_pkg::OP_SPLIT, '0, '0);
    issue_op(slt_pkg::OP_FIND, '1, '0);
    issue_op(slt_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    issue_op(slt_pkg::OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    issue_op(slt_pkg::OP_SPLIT, '0, '0);
    issue_op(slt_pkg::OP_SPLIT, '0, '0);
    issue_op(slt_pkg::OP_SPLIT, '0, '0);
    issue_op(slt_pkg::OP_SPLIT, '0, '0);

    // pause with nothing in flight at least once
    wait_drained();

    // random: splits are rare early so the table fills up and refuses inserts
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - 30) allow_idle = 1'b0;
      split_weight = (n < 100) ? 1 : 8;
      roll = $urandom_range(0, 99);
      if (roll < 60)                     op = slt_pkg::OP_INSERT;
      else if (roll < 95 - split_weight) op = slt_pkg::OP_FIND;
      else if (roll < 95)                op = slt_pkg::OP_SPLIT;
      else                               op = slt_pkg::OP_NONE;
      maybe_idle();
      issue_op(op, pick_key(), {$urandom, $urandom});
      if (n == 120) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("covered %0d inserts, %0d finds, %0d splits and %0d unused-code transactions",
             op_tally[slt_pkg::OP_INSERT], op_tally[slt_pkg::OP_FIND],
             op_tally[slt_pkg::OP_SPLIT], op_tally[slt_pkg::OP_NONE]);
    $display("including empty and full table, duplicate keys and extreme keys and values");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
